@@ rtl/grb_pkg.sv @@
// Shared types and constants of the graph reachability block.
package grb_pkg;

  localparam int unsigned NodeCountDef = 64;
  localparam int unsigned NodeIdxW     = 6;
  localparam int unsigned NodeFieldMax = 1 << NodeIdxW;

  typedef enum logic {
    OpInsert = 1'b0,
    OpQuery  = 1'b1
  } grb_op_e;

  typedef enum logic [2:0] {
    StIdle,
    StDecode,
    StInsChk,
    StSearch,
    StResp
  } grb_state_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic ins_upd;
    logic step;
    logic load_out;
  } grb_cmd_t;

  typedef struct packed {
    logic op_query;
    logic in_range;
    logic same_node;
    logic search_done;
    logic out_free;
  } grb_sts_t;

endpackage

@@ rtl/grb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module grb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/grb_ctrl.sv @@
// Sequencer of the graph reachability block: request flow and search control.
module grb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  grb_pkg::grb_sts_t  sts_i,
  output grb_pkg::grb_cmd_t  cmd_o
);
  import grb_pkg::*;

  grb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StDecode;
        end
      end
      StDecode: begin
        cmd_o.decode = 1'b1;
        if (!sts_i.in_range || (sts_i.op_query && sts_i.same_node)) begin
          state_d = StResp;
        end else if (sts_i.op_query) begin
          state_d = StSearch;
        end else begin
          state_d = StInsChk;
        end
      end
      StInsChk: begin
        cmd_o.ins_upd = 1'b1;
        state_d       = StResp;
      end
      StSearch: begin
        cmd_o.step = 1'b1;
        if (sts_i.search_done) begin
          state_d = StResp;
        end
      end
      StResp: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

@@ rtl/grb_dp.sv @@
// Datapath: adjacency store, seen and expanded masks, result and output registers.
module grb_dp #(
  parameter int unsigned NODE_COUNT = grb_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  grb_pkg::grb_cmd_t             cmd_i,
  output grb_pkg::grb_sts_t             sts_o,
  input  logic                          operation_i,
  input  logic [grb_pkg::NodeIdxW-1:0]  src_node_i,
  input  logic [grb_pkg::NodeIdxW-1:0]  dst_node_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          reachable_o,
  output logic                          duplicate_o
);
  import grb_pkg::*;

  // Node fields are six bits wide, so nodes beyond that range never occur.
  localparam int unsigned Nodes = (NODE_COUNT < NodeFieldMax) ? NODE_COUNT : NodeFieldMax;
  localparam int unsigned IdxW  = $clog2(Nodes);
  localparam logic [NodeIdxW:0] NodeLim = (NodeIdxW + 1)'(Nodes);
  localparam logic [Nodes-1:0]  RowOne  = Nodes'(1);

  logic                op_q;
  logic [NodeIdxW-1:0] src_q, dst_q;
  logic                res_reach_q, res_reach_d;
  logic                res_dup_q, res_dup_d;
  logic [Nodes-1:0]    seen_q, seen_d;
  logic [Nodes-1:0]    exp_q, exp_d;
  logic                inflight_q, inflight_d;
  logic [IdxW-1:0]     rd_addr_q, rd_addr_d;
  logic [Nodes-1:0]    row_vld_q, row_vld_d;
  logic                out_valid_q, out_valid_d;
  logic                out_reach_q, out_dup_q;

  logic [IdxW-1:0]     src_idx, dst_idx, pick;
  logic                in_range, same_node, has_pend, found, search_done, dst_bit;
  logic [Nodes-1:0]    pend, low, row_eff;
  logic                ram_re, ram_we;
  logic [IdxW-1:0]     ram_raddr;
  logic [Nodes-1:0]    ram_rdata, ram_wdata;

  assign src_idx   = src_q[IdxW-1:0];
  assign dst_idx   = dst_q[IdxW-1:0];
  assign in_range  = ({1'b0, src_q} < NodeLim) && ({1'b0, dst_q} < NodeLim);
  assign same_node = (src_q == dst_q);

  // A row never written reads as empty.
  assign row_eff = row_vld_q[rd_addr_q] ? ram_rdata : '0;
  assign dst_bit = row_eff[dst_idx];

  // Work list: nodes seen but not yet expanded; take the lowest one.
  assign pend     = seen_q & ~exp_q;
  assign low      = pend & (~pend + RowOne);
  assign has_pend = |pend;

  always_comb begin
    pick = '0;
    for (int i = 0; i < Nodes; i++) begin
      if (low[i]) begin
        pick = pick | IdxW'(i);
      end
    end
  end

  assign found       = inflight_q && dst_bit;
  assign search_done = found || (!has_pend && !inflight_q);

  always_comb begin
    res_reach_d = res_reach_q;
    res_dup_d   = res_dup_q;
    seen_d      = seen_q;
    exp_d       = exp_q;
    inflight_d  = inflight_q;
    row_vld_d   = row_vld_q;
    ram_re      = 1'b0;
    ram_raddr   = src_idx;
    ram_we      = 1'b0;
    ram_wdata   = row_eff | (RowOne << dst_idx);

    if (cmd_i.decode) begin
      res_reach_d = op_q && in_range && same_node;
      res_dup_d   = 1'b0;
      inflight_d  = 1'b0;
      if (in_range && (op_q == OpInsert)) begin
        ram_re = 1'b1;
      end
      if (in_range && (op_q == OpQuery) && !same_node) begin
        seen_d = RowOne << src_idx;
        exp_d  = '0;
      end
    end

    if (cmd_i.ins_upd) begin
      res_dup_d = dst_bit;
      if (!dst_bit) begin
        ram_we            = 1'b1;
        row_vld_d[src_idx] = 1'b1;
      end
    end

    if (cmd_i.step) begin
      if (search_done) begin
        res_reach_d = found;
        seen_d      = '0;
        exp_d       = '0;
        inflight_d  = 1'b0;
      end else begin
        if (inflight_q) begin
          seen_d = seen_q | row_eff;
        end
        inflight_d = has_pend;
        if (has_pend) begin
          ram_re    = 1'b1;
          ram_raddr = pick;
          exp_d     = exp_q | low;
        end
      end
    end
  end

  assign rd_addr_d = ram_re ? ram_raddr : rd_addr_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      exp_q       <= '0;
      inflight_q  <= 1'b0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      exp_q       <= exp_d;
      inflight_q  <= inflight_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      src_q <= src_node_i;
      dst_q <= dst_node_i;
    end
    if (cmd_i.load_out) begin
      out_reach_q <= res_reach_q;
      out_dup_q   <= res_dup_q;
    end
    res_reach_q <= res_reach_d;
    res_dup_q   <= res_dup_d;
    rd_addr_q   <= rd_addr_d;
  end

  grb_ram #(
    .Width (Nodes),
    .Depth (Nodes),
    .AddrW (IdxW)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (src_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.op_query    = (op_q == OpQuery);
  assign sts_o.in_range    = in_range;
  assign sts_o.same_node   = same_node;
  assign sts_o.search_done = search_done;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign reachable_o = out_reach_q;
  assign duplicate_o = out_dup_q;

endmodule

@@ rtl/graph_reachability_bfs.sv @@
// Top level of the directed-graph reachability block.
//
// Holds a directed graph over numbered nodes as an adjacency bit matrix (one
// RAM row per source node, one bit per destination) and answers one result
// request per input request. Operation insert sets the edge src->dst and
// reports duplicate when it was already present; operation query reports
// whether dst can be reached from src (a node always reaches itself). A node
// index at or above NODE_COUNT makes an insert a no-op and a query answer 0.
// The store is empty after reset: every row carries a valid flop, so a row
// never written reads as empty and no clearing pass is needed. Requests are
// handled one at a time. An insert reads the row, updates it and presents
// the result. A query searches the graph breadth first: a seen mask and an
// expanded mask form the work list; the lowest seen-but-unexpanded node
// has its row read from the single RAM read port and merged into the seen
// mask, one node at a time. The search ends as soon as dst shows up in a
// row or the work list drains. A finished result sits in an output
// register, so the next request is accepted while the previous result
// still waits to be taken.
module graph_reachability_bfs #(
  parameter int unsigned NODE_COUNT = grb_pkg::NodeCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [grb_pkg::NodeIdxW-1:0]  src_node_i,
  input  logic [grb_pkg::NodeIdxW-1:0]  dst_node_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          reachable_o,
  output logic                          duplicate_o
);
  import grb_pkg::*;

  grb_cmd_t cmd;
  grb_sts_t sts;

  // Sequencer: decode the request, run the insert update or the search steps.
  grb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and search datapath, plus the output register.
  grb_dp #(
    .NODE_COUNT (NODE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .src_node_i  (src_node_i),
    .dst_node_i  (dst_node_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .reachable_o (reachable_o),
    .duplicate_o (duplicate_o)
  );

endmodule

@@ rtl/grb_checker.sv @@
// Port-level checks of the graph reachability block, bound to the top level.
module grb_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic reachable_o,
  input logic duplicate_o
);

  logic [1:0] open_q, open_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign open_d  = open_q + 2'(in_acc) - 2'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(reachable_o) && $stable(duplicate_o))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reachable_o && duplicate_o))
    else $error("reachable and duplicate both set");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while one is being worked on");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (open_q != 2'd0))
    else $error("result without an open request");

endmodule

bind graph_reachability_bfs grb_sva u_grb_sva (.*);

@@ dv/grb_checker.sv @@
// Checker for the graph reachability block: tracks the graph, predicts and compares results.
module grb_checker #(
  parameter int unsigned NODE_COUNT = grb_pkg::NodeCountDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         operation_i,
  input  logic [grb_pkg::NodeIdxW-1:0] src_node_i,
  input  logic [grb_pkg::NodeIdxW-1:0] dst_node_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         reachable_i,
  input  logic                         duplicate_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import grb_pkg::*;

  typedef logic [NodeIdxW-1:0] node_t;

  typedef struct packed {
    logic reachable;
    logic duplicate;
  } answer_t;

  // Two-state rows start out empty, matching the cleared store.
  bit [NodeFieldMax-1:0]   edge_rows [NodeFieldMax];
  answer_t                 answer_q [$];
  int                      mismatches;

  // Breadth-first walk: expand the lowest seen node not yet expanded.
  function automatic logic path_exists(node_t src, node_t dst);
    logic [NodeFieldMax-1:0] seen;
    logic [NodeFieldMax-1:0] expanded;
    logic [NodeFieldMax-1:0] frontier;
    int unsigned             node;
    if (src == dst) return 1'b1;
    seen      = '0;
    seen[src] = 1'b1;
    expanded  = '0;
    frontier  = seen;
    while (frontier != '0) begin
      node = 0;
      while (!frontier[node]) node++;
      expanded[node] = 1'b1;
      if (edge_rows[node][dst]) return 1'b1;
      seen     = seen | edge_rows[node];
      frontier = seen & ~expanded;
    end
    return 1'b0;
  endfunction

  function automatic answer_t apply_request(grb_op_e op, node_t src, node_t dst);
    answer_t ans;
    logic    in_range;
    ans      = '0;
    in_range = (src < NODE_COUNT) && (dst < NODE_COUNT);
    if (op == OpInsert) begin
      if (in_range) begin
        if (edge_rows[src][dst]) ans.duplicate = 1'b1;
        else edge_rows[src][dst] = 1'b1;
      end
    end else if (in_range) begin
      ans.reachable = path_exists(src, dst);
    end
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result with no request pending: reachable %0b duplicate %0b",
                   $time, reachable_i, duplicate_i);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (reachable_i !== want.reachable) begin
            $display("%0t: reachable mismatch: expected %0b, actual %0b",
                     $time, want.reachable, reachable_i);
            mismatches++;
          end
          if (duplicate_i !== want.duplicate) begin
            $display("%0t: duplicate mismatch: expected %0b, actual %0b",
                     $time, want.duplicate, duplicate_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        answer_q.push_back(apply_request(grb_op_e'(operation_i), src_node_i, dst_node_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= answer_q.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the graph reachability block: stimulus, handshake pacing and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grb_pkg::*;

  typedef logic [NodeIdxW-1:0] node_t;

  localparam int unsigned RandomItems   = 1880;
  localparam int unsigned WatchdogLimit = 4000;
  // Longest query plus margin, for a search along a chain of nodes.
  localparam int unsigned DrainCycles   = 2 * NodeCountDef + 16;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid;
  logic  in_ready;
  logic  operation;
  node_t src_node;
  node_t dst_node;
  logic  out_valid;
  logic  out_ready;
  logic  reachable;
  logic  duplicate;

  int    send_idle_pct;
  int    recv_stall_pct;
  int    idle_cycles;
  int    fail_count;
  int    pending;

  // Every edge ever inserted, so later inserts can hit existing edges.
  logic [2*NodeIdxW-1:0] edge_log [$];

  graph_reachability_bfs DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .src_node_i  (src_node),
    .dst_node_i  (dst_node),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .reachable_o (reachable),
    .duplicate_o (duplicate)
  );

  grb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .operation_i  (operation),
    .src_node_i   (src_node),
    .dst_node_i   (dst_node),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .reachable_i  (reachable),
    .duplicate_i  (duplicate),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result side at random; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("** graph_reachability_bfs: FAILED **");
        $finish;
      end
    end
  end

  // Hold valid and payload until the request is taken. Insert random gaps first.
  task automatic send_request(grb_op_e op, node_t src, node_t dst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    src_node  <= src;
    dst_node  <= dst;
    if (op == OpInsert) edge_log.push_back({src, dst});
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly short forward edges so the graph stays layered and searches run deep;
  // backward edges only late and only among the upper nodes, so some pairs stay
  // unreachable until the end.
  task automatic send_random_insert(bit late);
    node_t                 src;
    node_t                 dst;
    logic [2*NodeIdxW-1:0] pick;
    int unsigned           kind;
    kind = $urandom_range(99);
    src  = node_t'($urandom_range(58, 0));
    dst  = src + node_t'($urandom_range(3, 1));
    if (dst > 59) dst = 6'd59;
    if (kind >= 40 && kind < 60) begin
      dst = node_t'($urandom_range(59, src + 1));
    end else if (kind >= 60 && kind < 80 && edge_log.size() != 0) begin
      pick = edge_log[$urandom_range(edge_log.size() - 1)];
      src  = pick[2*NodeIdxW-1:NodeIdxW];
      dst  = pick[NodeIdxW-1:0];
    end else if (kind >= 80 && kind < 90) begin
      src = node_t'($urandom_range(63));
      dst = src;
    end else if (kind >= 90 && late) begin
      src = node_t'($urandom_range(59, 41));
      dst = node_t'($urandom_range(src - 1, 40));
    end
    send_request(OpInsert, src, dst);
  endtask

  task automatic send_random_query();
    node_t src;
    node_t dst;
    src = node_t'($urandom_range(63));
    dst = ($urandom_range(9) == 0) ? src : node_t'($urandom_range(63));
    send_request(OpQuery, src, dst);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    operation      = 1'b0;
    src_node       = '0;
    dst_node       = '0;
    send_idle_pct  = 17;
    recv_stall_pct = 80;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty graph, equal nodes, self loops, duplicates,
    // extreme node indices, a short chain and a cycle closed over it.
    send_request(OpQuery, 6'd0, 6'd63);
    send_request(OpQuery, 6'd5, 6'd5);
    send_request(OpInsert, 6'd0, 6'd0);
    send_request(OpInsert, 6'd0, 6'd0);
    send_request(OpQuery, 6'd0, 6'd0);
    send_request(OpInsert, 6'd63, 6'd63);
    send_request(OpQuery, 6'd63, 6'd63);
    send_request(OpInsert, 6'd0, 6'd63);
    send_request(OpInsert, 6'd0, 6'd63);
    send_request(OpQuery, 6'd0, 6'd63);
    send_request(OpQuery, 6'd63, 6'd0);
    send_request(OpInsert, 6'd1, 6'd2);
    send_request(OpInsert, 6'd2, 6'd3);
    send_request(OpInsert, 6'd3, 6'd4);
    send_request(OpQuery, 6'd1, 6'd4);
    send_request(OpQuery, 6'd4, 6'd1);
    send_request(OpInsert, 6'd4, 6'd1);
    send_request(OpQuery, 6'd4, 6'd1);
    send_request(OpQuery, 6'd3, 6'd2);
    send_request(OpQuery, 6'd2, 6'd5);
    send_request(OpInsert, 6'd63, 6'd0);
    send_request(OpQuery, 6'd63, 6'd4);
    send_request(OpQuery, 6'd63, 6'd63);

    // Hold off until the block has handed back everything.
    wait_drained();

    // Three random phases: slow receiver, slow sender, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 80;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < RandomItems / 3; n++) begin
        if ($urandom_range(1)) send_random_query();
        else send_random_insert(phase * (RandomItems / 3) + n >= RandomItems / 2);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** graph_reachability_bfs: PASSED **");
    end else begin
      $display("** graph_reachability_bfs: FAILED **");
    end
    $finish;
  end

endmodule

@@ graph_reachability_bfs.f @@
rtl/grb_pkg.sv
rtl/grb_ram.sv
rtl/grb_ctrl.sv
rtl/grb_dp.sv
rtl/graph_reachability_bfs.sv
rtl/grb_checker.sv
dv/grb_checker.sv
dv/tb.sv
